>>> sv/vbcs_pkg.sv
// Package for the ventilator breath-cycle sequencer: field widths, codes,
// register reset values, timing constants and the shared struct types.
// No dependencies; every other file of the block takes it in.
package vbcs_pkg;

    localparam int FUNC_W    = 2;
    localparam int TIME_W    = 32;
    localparam int PRES_W    = 16;
    localparam int CFG_W     = 15;
    localparam int CFG_IDX_W = 3;
    localparam int PHASE_W   = 3;
    localparam int MODE_W    = 2;
    localparam int STATUS_W  = 3;

    // Item function codes
    localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_START = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_STOP  = 2'd2;

    // Phase codes as reported on the result channel
    localparam logic [PHASE_W-1:0] PHASE_IDLE    = 3'd0;
    localparam logic [PHASE_W-1:0] PHASE_START   = 3'd1;
    localparam logic [PHASE_W-1:0] PHASE_EXPIR   = 3'd2;
    localparam logic [PHASE_W-1:0] PHASE_PREPARE = 3'd3;
    localparam logic [PHASE_W-1:0] PHASE_INSPIR  = 3'd4;
    localparam logic [PHASE_W-1:0] PHASE_WAITAIR = 3'd5;
    localparam logic [PHASE_W-1:0] PHASE_PLATEAU = 3'd6;

    // Outflow valve modes
    localparam logic [MODE_W-1:0] VALVE_HIGH     = 2'd0;
    localparam logic [MODE_W-1:0] VALVE_END_INSP = 2'd1;
    localparam logic [MODE_W-1:0] VALVE_END_EXP  = 2'd2;

    // Start request status
    localparam logic [STATUS_W-1:0] STAT_NONE        = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_ACCEPTED    = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_TOP_SHORT   = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_INSP_SHORT  = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_PLAT_SHORT  = 3'd4;
    localparam logic [STATUS_W-1:0] STAT_EXPIR_SHORT = 3'd5;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TOP_SWITCH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INSPIRATION = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PLATEAU_END = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CYCLE       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SETUP       = 3'd4;

    // Register reset values
    localparam logic [CFG_W-1:0] TOP_SWITCH_RST  = 15'd50;
    localparam logic [CFG_W-1:0] INSPIRATION_RST = 15'd1000;
    localparam logic [CFG_W-1:0] PLATEAU_END_RST = 15'd1500;
    localparam logic [CFG_W-1:0] CYCLE_RST       = 15'd4000;
    localparam logic [CFG_W-1:0] SETUP_RST       = 15'd100;

    // Timing constants
    localparam logic [TIME_W-1:0]   START_OFFSET_MS = 32'd2000;
    localparam logic signed [16:0]  AIR_LEAD_MS     = 17'sd40;
    localparam logic [CFG_W-1:0]    MIN_TOP_MS      = 15'd50;
    localparam logic [CFG_W:0]      MIN_INSP_GAP_MS = 16'd100;
    localparam logic [CFG_W:0]      MIN_EXP_GAP_MS  = 16'd500;

    typedef enum logic [6:0] {
        PH_IDLE    = 7'b0000001,
        PH_START   = 7'b0000010,
        PH_EXPIR   = 7'b0000100,
        PH_PREPARE = 7'b0001000,
        PH_INSPIR  = 7'b0010000,
        PH_WAITAIR = 7'b0100000,
        PH_PLATEAU = 7'b1000000
    } phase_t;

    typedef struct packed {
        logic [CFG_W-1:0] top_switch;
        logic [CFG_W-1:0] inspiration;
        logic [CFG_W-1:0] plateau_end;
        logic [CFG_W-1:0] cycle;
        logic [CFG_W-1:0] setup;
    } cfg_t;

    typedef struct packed {
        logic [FUNC_W-1:0]        func;
        logic [TIME_W-1:0]        now_ms;
        logic                     sample_valid;
        logic signed [PRES_W-1:0] pressure;
    } item_t;

    typedef struct packed {
        phase_t                   phase;
        logic [TIME_W-1:0]        cycle_start;
        logic signed [PRES_W-1:0] last_pressure;
        logic signed [PRES_W-1:0] peak;
        logic signed [PRES_W-1:0] end_insp;
        logic signed [PRES_W-1:0] end_exp;
    } state_t;

    typedef struct packed {
        logic [PHASE_W-1:0]       phase;
        logic                     valve_set;
        logic [MODE_W-1:0]        valve_mode;
        logic                     air_start;
        logic                     air_stop;
        logic                     cycle_done;
        logic signed [PRES_W-1:0] peak_pressure;
        logic signed [PRES_W-1:0] end_insp_pressure;
        logic signed [PRES_W-1:0] end_exp_pressure;
        logic [STATUS_W-1:0]      start_status;
    } result_t;

    function automatic logic [PHASE_W-1:0] phase_code(input phase_t p);
        logic [PHASE_W-1:0] code;
        case (p)
            PH_IDLE:    code = PHASE_IDLE;
            PH_START:   code = PHASE_START;
            PH_EXPIR:   code = PHASE_EXPIR;
            PH_PREPARE: code = PHASE_PREPARE;
            PH_INSPIR:  code = PHASE_INSPIR;
            PH_WAITAIR: code = PHASE_WAITAIR;
            PH_PLATEAU: code = PHASE_PLATEAU;
            default:    code = PHASE_IDLE;
        endcase
        return code;
    endfunction

endpackage

>>> sv/vbcs_item_if.sv
// Input channel of the breath-cycle sequencer: tick, start and stop words.
// Depends on vbcs_pkg for field widths.
interface vbcs_item_if;
    logic                                       valid;
    logic                                       ready;
    logic [vbcs_pkg::FUNC_W-1:0]                func;
    logic [vbcs_pkg::TIME_W-1:0]                now_ms;
    logic                                       sample_valid;
    logic signed [vbcs_pkg::PRES_W-1:0]         pressure;

    modport source (output valid, func, now_ms, sample_valid, pressure, input ready);
    modport sink   (input valid, func, now_ms, sample_valid, pressure, output ready);
endinterface

>>> sv/vbcs_result_if.sv
// Result channel of the breath-cycle sequencer: one word per accepted item.
// Depends on vbcs_pkg for field widths.
interface vbcs_result_if;
    logic                                 valid;
    logic                                 ready;
    logic [vbcs_pkg::PHASE_W-1:0]         phase;
    logic                                 valve_set;
    logic [vbcs_pkg::MODE_W-1:0]          valve_mode;
    logic                                 air_start;
    logic                                 air_stop;
    logic                                 cycle_done;
    logic signed [vbcs_pkg::PRES_W-1:0]   peak_pressure;
    logic signed [vbcs_pkg::PRES_W-1:0]   end_insp_pressure;
    logic signed [vbcs_pkg::PRES_W-1:0]   end_exp_pressure;
    logic [vbcs_pkg::STATUS_W-1:0]        start_status;

    modport source (output valid, phase, valve_set, valve_mode, air_start, air_stop,
                    cycle_done, peak_pressure, end_insp_pressure, end_exp_pressure,
                    start_status, input ready);
    modport sink   (input valid, phase, valve_set, valve_mode, air_start, air_stop,
                    cycle_done, peak_pressure, end_insp_pressure, end_exp_pressure,
                    start_status, output ready);
endinterface

>>> sv/vbcs_cfg_if.sv
// Configuration write channel of the breath-cycle sequencer.
// Depends on vbcs_pkg for index and data widths.
interface vbcs_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [vbcs_pkg::CFG_IDX_W-1:0]  index;
    logic [vbcs_pkg::CFG_W-1:0]      data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> sv/vbcs_cfg_regs.sv
// Timing register file of the breath-cycle sequencer.
// Depends on vbcs_pkg and vbcs_cfg_if.
module vbcs_cfg_regs (
    input  logic          clk,
    input  logic          rst_n,
    vbcs_cfg_if.sink      cfg,
    output vbcs_pkg::cfg_t regs
);
    import vbcs_pkg::*;

    cfg_t regs_reg;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.top_switch  <= TOP_SWITCH_RST;
            regs_reg.inspiration <= INSPIRATION_RST;
            regs_reg.plateau_end <= PLATEAU_END_RST;
            regs_reg.cycle       <= CYCLE_RST;
            regs_reg.setup       <= SETUP_RST;
        end
        else if (cfg.valid)
        begin
            // Drop writes beyond the last register
            case (cfg.index)
                REG_TOP_SWITCH:  regs_reg.top_switch  <= cfg.data;
                REG_INSPIRATION: regs_reg.inspiration <= cfg.data;
                REG_PLATEAU_END: regs_reg.plateau_end <= cfg.data;
                REG_CYCLE:       regs_reg.cycle       <= cfg.data;
                REG_SETUP:       regs_reg.setup       <= cfg.data;
                default:         ;
            endcase
        end
    end

endmodule

>>> sv/vbcs_step.sv
// Next-state and result logic for one item of the breath-cycle sequencer.
// Depends on vbcs_pkg.
module vbcs_step (
    input  vbcs_pkg::cfg_t    cfg,
    input  vbcs_pkg::item_t   item,
    input  vbcs_pkg::state_t  cur,
    output vbcs_pkg::state_t  nxt,
    output vbcs_pkg::result_t res
);
    import vbcs_pkg::*;

    logic signed [TIME_W-1:0] elapsed;
    logic signed [16:0]       wait_lim;
    logic signed [PRES_W-1:0] peak_out;

    // Wrap-safe time since cycle start, read as two's complement
    assign elapsed  = signed'(item.now_ms - cur.cycle_start);
    assign wait_lim = signed'({2'b00, cfg.inspiration}) + signed'({2'b00, cfg.setup})
                      - AIR_LEAD_MS;

    always_comb
    begin
        nxt              = cur;
        res              = '0;
        res.valve_mode   = VALVE_HIGH;
        res.start_status = STAT_NONE;

        case (item.func)
            FUNC_TICK:
            begin
                if (item.sample_valid)
                begin
                    nxt.last_pressure = item.pressure;
                    if (item.pressure > cur.peak)
                        nxt.peak = item.pressure;
                end
                case (cur.phase)
                    PH_IDLE:    ;
                    PH_START:
                    begin
                        res.air_stop    = 1'b1;
                        nxt.cycle_start = item.now_ms - {17'd0, cfg.cycle} + START_OFFSET_MS;
                        res.valve_set   = 1'b1;
                        res.valve_mode  = VALVE_END_EXP;
                        nxt.peak        = '0;
                        nxt.end_exp     = '0;
                        nxt.phase       = PH_EXPIR;
                    end
                    PH_EXPIR:
                    begin
                        if (elapsed > signed'({17'd0, cfg.cycle}))
                        begin
                            nxt.end_exp     = nxt.last_pressure;
                            res.cycle_done  = 1'b1;
                            res.valve_set   = 1'b1;
                            res.valve_mode  = VALVE_HIGH;
                            nxt.cycle_start = item.now_ms;
                            nxt.phase       = PH_PREPARE;
                        end
                    end
                    PH_PREPARE:
                    begin
                        if (elapsed > signed'({17'd0, cfg.setup}))
                        begin
                            res.air_start = 1'b1;
                            nxt.phase     = PH_INSPIR;
                        end
                    end
                    PH_INSPIR:
                    begin
                        if (elapsed > signed'({17'd0, cfg.top_switch}))
                        begin
                            res.valve_set  = 1'b1;
                            res.valve_mode = VALVE_END_INSP;
                            nxt.phase      = PH_WAITAIR;
                        end
                    end
                    PH_WAITAIR:
                    begin
                        if (elapsed > TIME_W'(wait_lim))
                        begin
                            res.valve_set  = 1'b1;
                            res.valve_mode = VALVE_END_INSP;
                            nxt.phase      = PH_PLATEAU;
                        end
                    end
                    PH_PLATEAU:
                    begin
                        if (elapsed > signed'({17'd0, cfg.plateau_end}))
                        begin
                            nxt.end_insp   = nxt.last_pressure;
                            res.valve_set  = 1'b1;
                            res.valve_mode = VALVE_END_EXP;
                            nxt.phase      = PH_EXPIR;
                        end
                    end
                    default:    nxt.phase = PH_IDLE;
                endcase
            end
            FUNC_START:
            begin
                // First failing relation wins
                if (cfg.top_switch < MIN_TOP_MS)
                    res.start_status = STAT_TOP_SHORT;
                else if ({1'b0, cfg.inspiration} < {1'b0, cfg.top_switch} + MIN_INSP_GAP_MS)
                    res.start_status = STAT_INSP_SHORT;
                else if ({1'b0, cfg.plateau_end} < {1'b0, cfg.inspiration} + MIN_INSP_GAP_MS)
                    res.start_status = STAT_PLAT_SHORT;
                else if ({1'b0, cfg.cycle} < {1'b0, cfg.plateau_end} + MIN_EXP_GAP_MS)
                    res.start_status = STAT_EXPIR_SHORT;
                else
                begin
                    res.start_status = STAT_ACCEPTED;
                    nxt.phase        = PH_START;
                end
            end
            FUNC_STOP:
            begin
                res.valve_set  = 1'b1;
                res.valve_mode = VALVE_END_EXP;
                res.air_stop   = 1'b1;
                nxt.phase      = PH_IDLE;
            end
            default:    ;
        endcase

        // Report the finished cycle's peak, then clear it
        peak_out = nxt.peak;
        if (res.cycle_done)
            nxt.peak = '0;

        res.phase             = phase_code(nxt.phase);
        res.peak_pressure     = peak_out;
        res.end_insp_pressure = nxt.end_insp;
        res.end_exp_pressure  = nxt.end_exp;
    end

endmodule

>>> sv/ventilator_breath_cycle_sequencer.sv
// Top level of the ventilator breath-cycle sequencer: input register, phase
// state, result register. Depends on vbcs_pkg, the three channel interfaces,
// vbcs_cfg_regs and vbcs_step.
//
//  channel  | dir | words                                   | accepted when
//  ---------+-----+-----------------------------------------+----------------------
//  item     | in  | func, now_ms, sample_valid, pressure    | item.valid & ready
//  result   | out | phase, valve/air commands, pressures,   | result.valid & ready
//           |     | start_status                            |
//  cfg      | in  | index, data (15-bit timing registers)   | cfg.valid (ready = 1)
//
// One item per clock sustained while result.ready holds; an accepted item is held
// in the input register, then its result in the result register that the phase state
// updates alongside. All step logic is a single combinational pass between them.
// Reset returns the timing registers to their defaults and the phase to idle.
// A stalled result holds in the result register while the input register
// takes one more item; item.ready falls only when both are full and blocked.
module ventilator_breath_cycle_sequencer (
    input  logic         clk,
    input  logic         rst_n,
    vbcs_item_if.sink     item,
    vbcs_result_if.source result,
    vbcs_cfg_if.sink      cfg
);
    import vbcs_pkg::*;

    cfg_t    regs;
    item_t   item_reg;
    logic    item_valid_reg;
    state_t  state_reg;
    state_t  state_next;
    result_t result_reg;
    result_t result_next;
    logic    result_valid_reg;
    logic    advance;

    vbcs_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    vbcs_step u_step (
        .cfg  (regs),
        .item (item_reg),
        .cur  (state_reg),
        .nxt  (state_next),
        .res  (result_next)
    );

    // Advance the held item into the result register when that slot is free
    assign advance    = item_valid_reg && (!result_valid_reg || result.ready);
    assign item.ready = !item_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
            state_reg        <= '{phase: PH_IDLE, default: '0};
        end
        else
        begin
            if (item.ready)
                item_valid_reg <= item.valid;
            if (advance)
            begin
                result_valid_reg <= 1'b1;
                state_reg        <= state_next;
            end
            else if (result.ready)
                result_valid_reg <= 1'b0;
        end
    end

    // Payload registers: no reset
    always_ff @(posedge clk)
    begin
        if (item.ready && item.valid)
        begin
            item_reg.func         <= item.func;
            item_reg.now_ms       <= item.now_ms;
            item_reg.sample_valid <= item.sample_valid;
            item_reg.pressure     <= item.pressure;
        end
        if (advance)
            result_reg <= result_next;
    end

    assign result.valid             = result_valid_reg;
    assign result.phase             = result_reg.phase;
    assign result.valve_set         = result_reg.valve_set;
    assign result.valve_mode        = result_reg.valve_mode;
    assign result.air_start         = result_reg.air_start;
    assign result.air_stop          = result_reg.air_stop;
    assign result.cycle_done        = result_reg.cycle_done;
    assign result.peak_pressure     = result_reg.peak_pressure;
    assign result.end_insp_pressure = result_reg.end_insp_pressure;
    assign result.end_exp_pressure  = result_reg.end_exp_pressure;
    assign result.start_status      = result_reg.start_status;

    // A held item that cannot advance must still be there next cycle
    a_item_held: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid_reg && !advance |=> item_valid_reg)
        else $error("held item lost");

    // A finished cycle always moves on to prepare
    a_done_phase: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && result_reg.cycle_done |-> result_reg.phase == PHASE_PREPARE)
        else $error("cycle_done outside prepare entry");

    // Air starts only on entry to inspiration
    a_air_phase: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && result_reg.air_start |-> result_reg.phase == PHASE_INSPIR)
        else $error("air_start outside inspiration entry");

    // An accepted start request lands in the start phase
    a_start_phase: assert property (@(posedge clk) disable iff (!rst_n)
        advance && result_next.start_status == STAT_ACCEPTED
        |=> state_reg.phase == PH_START)
        else $error("accepted start did not arm");

    // No valve mode without a valve command
    a_mode_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && !result_reg.valve_set |-> result_reg.valve_mode == VALVE_HIGH)
        else $error("valve_mode set without valve_set");

endmodule
